### rtl/backward_lz_decompressor_defines.svh
// Assertion macros shared by the backward LZ decompressor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BACKWARD_LZ_DECOMPRESSOR_DEFINES_SVH
`define BACKWARD_LZ_DECOMPRESSOR_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BLZ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("blz: invariant violated");

// A condition that implies another in the same cycle.
`define BLZ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blz: same-cycle implication violated");

// A condition that implies another in the following cycle.
`define BLZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blz: next-cycle implication violated");

`endif

### rtl/blz_pkg.sv
// Shared types and constants of the backward LZ decompressor.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package blz_pkg;

   localparam int WINDOW_BYTES_DEF = 8192;

   localparam int DATA_W     = 8;
   localparam int LEN_W      = 24;
   localparam int STATUS_W   = 3;
   localparam int CNT_W      = 5;
   localparam int DIST_W     = 13;
   localparam int BITS_W     = 4;
   localparam int PHASE_W    = 2;
   localparam int RSP_DATA_W = 16;

   // Parse phase of the compressed stream.
   localparam logic [PHASE_W-1:0] PH_FLAG = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ITEM = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LOW  = 2'd2;

   // Status codes reported in the final result of a stream.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_DIST = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                take;
      logic                clear_stream;
      logic                set_failed;
      logic                load_flag;
      logic                store_high;
      logic                advance;
      logic                start_copy;
      logic                rd_issue;
      logic                emit_lit;
      logic                emit_copy;
      logic                emit_status;
      logic [STATUS_W-1:0] status_code;
   } blz_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic               last;
      logic               failed;
      logic [PHASE_W-1:0] phase;
      logic               flag_msb;
      logic               room_zero;
      logic               count_over;
      logic               dist_bad;
      logic               count_one;
      logic               len_match;
      logic               out_free;
   } blz_stat_type;

endpackage

`default_nettype wire

### rtl/backward_lz_decompressor.sv
// Top level of the backward LZ decompressor: stream ports and configuration.
// Depends on blz_pkg, blz_ctrl, blz_datapath and blz_ram.
//
// Usage: the compressed region is fed one byte per req beat, highest address
// first, with req_tlast on its final byte. Decompressed bytes leave on the rsp
// channel, also highest address first, with rsp_tuser low. Every stream ends
// in one status beat (rsp_tuser high, rsp_tlast high) that carries the code:
// ok, output overflow, bad distance, truncated token or output short. After
// an error the remaining bytes of the stream are taken and dropped until the
// byte marked req_tlast. csr_write_data sets the expected output length. The
// user must write it only while the block is idle; the block does not enforce it.
// Timing: a beat is taken, then decoded in the next cycle. A flag byte or a
// token high byte is done once decoded; a literal then goes through a write state,
// and a token low byte starts a copy of 3 to 18 bytes, each read from the
// history RAM and then written back at the output. A status beat has its own state.
// Reset clears the stream state and the length register; the history window
// needs no clearing. When the receiver stalls, the result waits in the output
// register and the block holds req_tready low until it can move on.
`default_nettype none

module backward_lz_decompressor #(
   parameter int WINDOW_BYTES = blz_pkg::WINDOW_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Compressed input channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [blz_pkg::DATA_W-1:0]      req_tdata,   // [7:0] comp_byte
   input  wire logic                            req_tlast,   // last_in
   // Result channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [blz_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] data_byte, [10:8] status
   output logic                                 rsp_tuser,   // [0] is_status
   output logic                                 rsp_tlast,   // last_out
   // Configuration: expected output length.
   input  wire logic                            csr_write_en,
   input  wire logic [blz_pkg::LEN_W-1:0]       csr_write_data
);

   blz_pkg::blz_cmd_type         cmd;
   blz_pkg::blz_stat_type        stat;
   logic [blz_pkg::DATA_W-1:0]   out_data;
   logic [blz_pkg::STATUS_W-1:0] out_status;

   blz_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   blz_datapath #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .in_byte        (req_tdata),
      .in_last        (req_tlast),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .out_ready      (rsp_tready),
      .cmd            (cmd),
      .stat           (stat),
      .out_valid      (rsp_tvalid),
      .out_data       (out_data),
      .out_is_status  (rsp_tuser),
      .out_status     (out_status),
      .out_last       (rsp_tlast)
   );

   // Pack the result fields, zero padded to whole bytes.
   assign rsp_tdata = {
      {(blz_pkg::RSP_DATA_W - blz_pkg::DATA_W - blz_pkg::STATUS_W){1'b0}},
      out_status,
      out_data
   };

endmodule

`default_nettype wire

### rtl/blz_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on blz_pkg for its default depth; used for the history window.
`default_nettype none

module blz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = blz_pkg::WINDOW_BYTES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/blz_datapath.sv
// Datapath of the backward LZ decompressor: stream state, history window and
// output register. Depends on blz_pkg and blz_ram; driven by blz_ctrl.
`default_nettype none

module blz_datapath #(
   parameter int WINDOW_BYTES = blz_pkg::WINDOW_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [blz_pkg::DATA_W-1:0]        in_byte,
   input  wire logic                              in_last,
   input  wire logic                              csr_write_en,
   input  wire logic [blz_pkg::LEN_W-1:0]         csr_write_data,
   input  wire logic                              out_ready,
   input  wire blz_pkg::blz_cmd_type              cmd,
   output blz_pkg::blz_stat_type                  stat,
   output logic                                   out_valid,
   output logic      [blz_pkg::DATA_W-1:0]        out_data,
   output logic                                   out_is_status,
   output logic      [blz_pkg::STATUS_W-1:0]      out_status,
   output logic                                   out_last
);

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam int PW = AW + 1;

   // Control state.
   logic [blz_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [blz_pkg::BITS_W-1:0]  bits_ff, bits_in;
   logic [blz_pkg::LEN_W-1:0]   produced_ff, produced_in;
   logic                        failed_ff, failed_in;
   logic [AW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [blz_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                        out_valid_ff, out_valid_in;

   // Payload registers.
   logic [blz_pkg::DATA_W-1:0]   byte_ff, byte_in;
   logic                         last_ff, last_in;
   logic [blz_pkg::DATA_W-1:0]   flag_ff, flag_in;
   logic [blz_pkg::DATA_W-1:0]   high_ff, high_in;
   logic [AW-1:0]                rd_ptr_ff, rd_ptr_in;
   logic [blz_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [blz_pkg::DATA_W-1:0]   out_data_ff, out_data_in;
   logic                         out_user_ff, out_user_in;
   logic [blz_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic                         out_last_ff, out_last_in;

   logic [2*blz_pkg::DATA_W-1:0] token_w;
   logic [blz_pkg::CNT_W-1:0]    count_w;
   logic [blz_pkg::DIST_W-1:0]   dist_w;
   logic [blz_pkg::LEN_W-1:0]    room_w;
   logic [PW-1:0]                back_w;
   logic [PW-1:0]                rd_start_w;
   logic [blz_pkg::BITS_W-1:0]   bits_dec_w;
   logic                         out_free_w;
   logic                         ram_we_w;
   logic [blz_pkg::DATA_W-1:0]   ram_wdata_w;
   logic [blz_pkg::DATA_W-1:0]   ram_rdata_w;

   assign token_w = {high_ff, byte_ff};
   assign count_w = {1'b0, token_w[15:12]} + blz_pkg::CNT_W'(3);
   assign dist_w  = {1'b0, token_w[11:0]} + blz_pkg::DIST_W'(2);
   assign room_w  = (produced_ff >= len_ff) ? '0 : (len_ff - produced_ff);

   // Source of the first copied byte, one distance plus one behind the write
   // pointer, wrapped around the window.
   assign back_w     = {1'b0, wr_ptr_ff} - PW'(dist_w) - PW'(1);
   assign rd_start_w = back_w[PW-1] ? (back_w + PW'(WINDOW_BYTES)) : back_w;

   assign bits_dec_w = (bits_ff != '0) ? (bits_ff - 1'b1) : '0;
   assign out_free_w = !out_valid_ff || out_ready;

   assign ram_we_w    = cmd.emit_lit || cmd.emit_copy;
   assign ram_wdata_w = cmd.emit_lit ? byte_ff : ram_rdata_w;

   blz_ram #(
      .WIDTH (blz_pkg::DATA_W),
      .DEPTH (WINDOW_BYTES)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we_w),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wdata_w),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata_w)
   );

   always_comb begin
      phase_in      = phase_ff;
      bits_in       = bits_ff;
      produced_in   = produced_ff;
      failed_in     = failed_ff;
      wr_ptr_in     = wr_ptr_ff;
      len_in        = len_ff;
      out_valid_in  = out_valid_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      flag_in       = flag_ff;
      high_in       = high_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      out_data_in   = out_data_ff;
      out_user_in   = out_user_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      if (csr_write_en) begin
         len_in = csr_write_data;
      end

      if (cmd.take) begin
         byte_in = in_byte;
         last_in = in_last;
      end

      if (cmd.load_flag) begin
         flag_in  = byte_ff;
         bits_in  = blz_pkg::BITS_W'(8);
         phase_in = blz_pkg::PH_ITEM;
      end

      if (cmd.store_high) begin
         high_in  = byte_ff;
         phase_in = blz_pkg::PH_LOW;
      end

      if (cmd.advance) begin
         flag_in  = {flag_ff[blz_pkg::DATA_W-2:0], 1'b0};
         bits_in  = bits_dec_w;
         phase_in = (bits_dec_w != '0) ? blz_pkg::PH_ITEM : blz_pkg::PH_FLAG;
      end

      if (cmd.start_copy) begin
         count_in  = count_w;
         rd_ptr_in = rd_start_w[AW-1:0];
      end

      if (cmd.emit_lit || cmd.emit_copy) begin
         produced_in = produced_ff + 1'b1;
         wr_ptr_in   = (wr_ptr_ff == AW'(WINDOW_BYTES - 1)) ? '0 : (wr_ptr_ff + 1'b1);
      end

      if (cmd.emit_copy) begin
         count_in  = count_ff - 1'b1;
         rd_ptr_in = (rd_ptr_ff == AW'(WINDOW_BYTES - 1)) ? '0 : (rd_ptr_ff + 1'b1);
      end

      // Output register: a new result replaces one that is taken this cycle.
      if (cmd.emit_lit || cmd.emit_copy || cmd.emit_status) begin
         out_valid_in  = 1'b1;
         out_data_in   = cmd.emit_status ? '0 : ram_wdata_w;
         out_user_in   = cmd.emit_status;
         out_status_in = cmd.emit_status ? cmd.status_code : blz_pkg::ST_OK;
         out_last_in   = cmd.emit_status;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.set_failed) begin
         failed_in = 1'b1;
      end

      if (cmd.clear_stream) begin
         phase_in    = blz_pkg::PH_FLAG;
         flag_in     = '0;
         bits_in     = '0;
         high_in     = '0;
         produced_in = '0;
         failed_in   = 1'b0;
         wr_ptr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= blz_pkg::PH_FLAG;
         bits_ff      <= '0;
         produced_ff  <= '0;
         failed_ff    <= 1'b0;
         wr_ptr_ff    <= '0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
         flag_ff      <= '0;
         high_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         produced_ff  <= produced_in;
         failed_ff    <= failed_in;
         wr_ptr_ff    <= wr_ptr_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
         flag_ff      <= flag_in;
         high_ff      <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      rd_ptr_ff     <= rd_ptr_in;
      count_ff      <= count_in;
      out_data_ff   <= out_data_in;
      out_user_ff   <= out_user_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      stat.last       = last_ff;
      stat.failed     = failed_ff;
      stat.phase      = phase_ff;
      stat.flag_msb   = flag_ff[blz_pkg::DATA_W-1];
      stat.room_zero  = (room_w == '0);
      stat.count_over = ({{(blz_pkg::LEN_W - blz_pkg::CNT_W){1'b0}}, count_w} > room_w);
      stat.dist_bad   = ({{(blz_pkg::LEN_W - blz_pkg::DIST_W){1'b0}}, dist_w} >= produced_ff);
      stat.count_one  = (count_ff == blz_pkg::CNT_W'(1));
      stat.len_match  = (produced_ff == len_ff);
      stat.out_free   = out_free_w;
   end

   assign out_valid     = out_valid_ff;
   assign out_data      = out_data_ff;
   assign out_is_status = out_user_ff;
   assign out_status    = out_status_ff;
   assign out_last      = out_last_ff;

`include "backward_lz_decompressor_defines.svh"

   `BLZ_ASSERT_IMPL(a_emit_into_free_slot, clock, reset, cmd.emit_lit || cmd.emit_copy || cmd.emit_status, out_free_w)
   `BLZ_ASSERT_IMPL(a_copy_count_live, clock, reset, cmd.emit_copy, count_ff != '0)

endmodule

`default_nettype wire

### rtl/blz_ctrl.sv
// Controller of the backward LZ decompressor: sequences one input beat at a
// time and issues datapath commands. Depends on blz_pkg.
`default_nettype none

module blz_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire blz_pkg::blz_stat_type stat,
   output blz_pkg::blz_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_LIT     = 3'd2;
   localparam logic [2:0] S_COPY_RD = 3'd3;
   localparam logic [2:0] S_COPY_WR = 3'd4;
   localparam logic [2:0] S_ERR     = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [blz_pkg::STATUS_W-1:0] err_ff, err_in;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      cmd      = '0;

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.take = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.failed) begin
               cmd.clear_stream = stat.last;
               state_in         = S_IDLE;
            end else begin
               case (stat.phase)
                  blz_pkg::PH_FLAG: begin
                     cmd.load_flag = 1'b1;
                     state_in      = stat.last ? S_FINISH : S_IDLE;
                  end
                  blz_pkg::PH_ITEM: begin
                     if (stat.flag_msb) begin
                        if (stat.last) begin
                           err_in   = blz_pkg::ST_TRUNC;
                           state_in = S_ERR;
                        end else begin
                           cmd.store_high = 1'b1;
                           state_in       = S_IDLE;
                        end
                     end else begin
                        cmd.advance = 1'b1;
                        if (stat.room_zero) begin
                           err_in   = blz_pkg::ST_OVERFLOW;
                           state_in = S_ERR;
                        end else begin
                           state_in = S_LIT;
                        end
                     end
                  end
                  blz_pkg::PH_LOW: begin
                     cmd.advance = 1'b1;
                     if (stat.count_over) begin
                        err_in   = blz_pkg::ST_OVERFLOW;
                        state_in = S_ERR;
                     end else if (stat.dist_bad) begin
                        err_in   = blz_pkg::ST_BAD_DIST;
                        state_in = S_ERR;
                     end else begin
                        cmd.start_copy = 1'b1;
                        state_in       = S_COPY_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_LIT: begin
            if (stat.out_free) begin
               cmd.emit_lit = 1'b1;
               state_in     = stat.last ? S_FINISH : S_IDLE;
            end
         end
         S_COPY_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_COPY_WR;
         end
         S_COPY_WR: begin
            if (stat.out_free) begin
               cmd.emit_copy = 1'b1;
               if (stat.count_one) begin
                  state_in = stat.last ? S_FINISH : S_IDLE;
               end else begin
                  state_in = S_COPY_RD;
               end
            end
         end
         S_ERR: begin
            if (stat.out_free) begin
               cmd.emit_status  = 1'b1;
               cmd.status_code  = err_ff;
               cmd.clear_stream = stat.last;
               cmd.set_failed   = !stat.last;
               state_in         = S_IDLE;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit_status  = 1'b1;
               cmd.status_code  = stat.len_match ? blz_pkg::ST_OK : blz_pkg::ST_SHORT;
               cmd.clear_stream = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
   end

`include "backward_lz_decompressor_defines.svh"

   `BLZ_ASSERT_ALWAYS(a_one_emit_at_most, clock, reset, $onehot0({cmd.emit_lit, cmd.emit_copy, cmd.emit_status}))
   `BLZ_ASSERT_NEXT(a_read_then_write, clock, reset, cmd.rd_issue, state_ff == S_COPY_WR)
   `BLZ_ASSERT_NEXT(a_accept_then_decode, clock, reset, in_valid && in_ready, state_ff == S_DECODE)

endmodule

`default_nettype wire
